// ===== rtl/core/mkds_pkg.sv =====
// ----------------------------------------------------------------------------
// mkds_pkg
// Shared types and constants for the matrix key debounce scanner.
// ----------------------------------------------------------------------------
package mkds_pkg;

  localparam int unsigned LevelBits = 8;
  localparam int unsigned RowInW    = 3;
  localparam int unsigned ColIdxW   = 3;
  localparam int unsigned KeyIdW    = 6;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;

  localparam logic [CfgIdxW-1:0]  CfgPressTicks   = 8'd0;
  localparam logic [CfgIdxW-1:0]  CfgReleaseTicks = 8'd1;
  localparam logic [CfgDataW-1:0] TicksReset      = 16'd2;

  typedef enum logic [1:0] {
    PhIdle      = 2'd0,
    PhPressDb   = 2'd1,
    PhPressed   = 2'd2,
    PhReleaseDb = 2'd3
  } key_phase_e;

endpackage

// ===== rtl/core/matrix_key_debounce_scanner.sv =====
// ----------------------------------------------------------------------------
// matrix_key_debounce_scanner
// Per-key four-phase debounce over a scanned key matrix. Key state is kept
// per row in two synchronous memories; confirmed press and release events
// are sent out one beat per event in column order.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid / tready        | tdata: row_index, column_levels
//  m_axis   | out | tvalid / tready        | tdata: key_id; tuser: event_kind;
//           |     |                        | tlast: last_event
//  cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A row beat is read from the state memories in its accept cycle, then updated
// and written back from the row stage once that stage advances; a back-to-back
// beat on the same row takes the written data through a forwarding register.
// Rows are accepted one per cycle while the input is not stalled; a row with
// events sends them out one beat per event. Reset clears per-row valid bits at
// once, no clearing pass. The input stalls only while a row with events waits
// for the output event register to drain.
// ----------------------------------------------------------------------------
module matrix_key_debounce_scanner
  import mkds_pkg::*;
#(
  parameter int unsigned ROWS      = 8,
  parameter int unsigned COLS      = 8,
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [2:0] row_index, [10:3] column_levels
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [5:0] key_id
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  // [0] event_kind
  output logic                m_axis_tuser_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ScanCols = (COLS < LevelBits) ? COLS : LevelBits;
  localparam int unsigned RowW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CmpW     = (TICK_BITS > CfgDataW) ? TICK_BITS : CfgDataW;
  localparam int unsigned KeyFullW = 9;

  typedef key_phase_e [ScanCols-1:0]  row_phase_t;
  typedef logic [ScanCols-1:0][TICK_BITS-1:0] row_ticks_t;

  // configuration
  logic [CfgDataW-1:0] press_thr_q, release_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q   <= TicksReset;
      release_thr_q <= TicksReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgPressTicks) begin
        press_thr_q <= cfg_data_i;
      end else if (cfg_index_i == CfgReleaseTicks) begin
        release_thr_q <= cfg_data_i;
      end
    end
  end

  // input side
  logic [RowInW-1:0]    in_row;
  logic [LevelBits-1:0] in_lvl;
  logic                 in_fire, in_range;
  logic [RowW-1:0]      in_addr;

  assign in_row   = s_axis_tdata_i[RowInW-1:0];
  assign in_lvl   = s_axis_tdata_i[RowInW +: LevelBits];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = (32'(in_row) < ROWS);
  assign in_addr  = RowW'(in_row);

  // state memories
  row_phase_t phase_mem [ROWS];
  row_ticks_t ticks_mem [ROWS];
  logic [ROWS-1:0] row_vld_q;

  row_phase_t rd_phase_q, fwd_phase_q, wr_phase;
  row_ticks_t rd_ticks_q, fwd_ticks_q, wr_ticks;
  logic       rd_vld_q, fwd_hit_q;

  logic                 s1_valid_q, s1_adv, mem_we;
  logic [RowW-1:0]      s1_row_q;
  logic [RowInW-1:0]    s1_rin_q;
  logic [ScanCols-1:0]  s1_lvl_q;
  logic [ScanCols-1:0]  ev_mask, ev_press;

  assign mem_we = s1_adv;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      phase_mem[s1_row_q] <= wr_phase;
      ticks_mem[s1_row_q] <= wr_ticks;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_phase_q  <= phase_mem[in_addr];
      rd_ticks_q  <= ticks_mem[in_addr];
      fwd_phase_q <= wr_phase;
      fwd_ticks_q <= wr_ticks;
      s1_row_q    <= in_addr;
      s1_rin_q    <= in_row;
      s1_lvl_q    <= in_lvl[ScanCols-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      fwd_hit_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld_q[s1_row_q] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_q   <= row_vld_q[in_addr];
        fwd_hit_q  <= mem_we && (s1_row_q == in_addr);
        s1_valid_q <= in_range;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // per-key update
  always_comb begin
    key_phase_e           ph;
    logic [TICK_BITS-1:0] tk, tk_inc;
    logic                 high;
    wr_phase = '{default: PhIdle};
    wr_ticks = '0;
    ev_mask  = '0;
    ev_press = '0;
    for (int c = 0; c < ScanCols; c++) begin
      if (fwd_hit_q) begin
        ph = fwd_phase_q[c];
        tk = fwd_ticks_q[c];
      end else if (rd_vld_q) begin
        ph = rd_phase_q[c];
        tk = rd_ticks_q[c];
      end else begin
        ph = PhIdle;
        tk = '0;
      end
      high   = s1_lvl_q[c];
      tk_inc = (tk == {TICK_BITS{1'b1}}) ? tk : tk + TICK_BITS'(1);
      wr_phase[c] = ph;
      wr_ticks[c] = tk;
      case (ph)
        PhIdle: begin
          if (!high) begin
            wr_phase[c] = PhPressDb;
            wr_ticks[c] = '0;
          end
        end
        PhPressDb: begin
          if (!high) begin
            if (CmpW'(tk_inc) >= CmpW'(press_thr_q)) begin
              wr_phase[c] = PhPressed;
              wr_ticks[c] = '0;
              ev_mask[c]  = 1'b1;
              ev_press[c] = 1'b1;
            end else begin
              wr_ticks[c] = tk_inc;
            end
          end
        end
        PhPressed: begin
          if (high) begin
            wr_phase[c] = PhReleaseDb;
            wr_ticks[c] = '0;
          end
        end
        PhReleaseDb: begin
          if (high) begin
            if (CmpW'(tk_inc) >= CmpW'(release_thr_q)) begin
              wr_phase[c] = PhIdle;
              wr_ticks[c] = '0;
              ev_mask[c]  = 1'b1;
            end else begin
              wr_ticks[c] = tk_inc;
            end
          end
        end
        default: begin
          wr_phase[c] = PhIdle;
        end
      endcase
    end
    if (!s1_valid_q) begin
      ev_mask  = '0;
      ev_press = '0;
    end
  end

  // event emitter
  logic [ScanCols-1:0] em_mask_q, em_mask_d, em_press_q;
  logic [RowInW-1:0]   em_row_q;
  logic                out_fire, em_free, em_load;
  logic [ColIdxW-1:0]  col_idx;
  logic [KeyFullW-1:0] key_full;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign em_free  = (em_mask_q == '0) || (out_fire && ($countones(em_mask_q) == 1));
  assign s1_adv   = s1_valid_q && ((ev_mask == '0) || em_free);
  assign em_load  = s1_adv && (ev_mask != '0);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  always_comb begin
    em_mask_d = em_mask_q;
    if (em_load) begin
      em_mask_d = ev_mask;
    end else if (out_fire) begin
      em_mask_d = em_mask_q & (em_mask_q - ScanCols'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_mask_q <= '0;
    end else begin
      em_mask_q <= em_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load) begin
      em_press_q <= ev_press;
      em_row_q   <= s1_rin_q;
    end
  end

  always_comb begin
    col_idx = '0;
    for (int c = ScanCols - 1; c >= 0; c--) begin
      if (em_mask_q[c]) begin
        col_idx = ColIdxW'(c);
      end
    end
  end

  assign key_full        = KeyFullW'(em_row_q) * KeyFullW'(COLS) + KeyFullW'(col_idx);
  assign m_axis_tvalid_o = (em_mask_q != '0);
  assign m_axis_tdata_o  = OutDataW'(key_full[KeyIdW-1:0]);
  assign m_axis_tuser_o  = em_press_q[col_idx];
  assign m_axis_tlast_o  = ($countones(em_mask_q) == 1);

  // checks
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_row_q) && $stable(s1_lvl_q)))
    else $error("stalled row stage changed");

  a_em_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_load |-> ((em_mask_q == '0) || (out_fire && ($countones(em_mask_q) == 1))))
    else $error("event register overwritten with events pending");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && (ev_mask != '0) && (em_mask_q != '0)))
    else $error("input stalled without pending events");

  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mem_we && (s1_row_q == in_addr)) |=> fwd_hit_q)
    else $error("same-row write not forwarded");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matrix_key_debounce_scanner. Row scans are streamed
// in with random gaps and event beats drained with random back-pressure. A
// scoreboard tracks each key's debounce phase and tick count, predicts the
// press and release beats of every accepted row, and checks the output beats
// in order. Thresholds are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import mkds_pkg::*;

  localparam int unsigned ROWS      = 8;
  localparam int unsigned COLS      = 8;
  localparam int unsigned TICK_BITS = 16;
  localparam int unsigned NumKeys   = ROWS * COLS;
  localparam int unsigned ScanCols  = (COLS < LevelBits) ? COLS : LevelBits;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned RowsPerPhase  = 20;
  localparam logic [TICK_BITS-1:0] TickMax = '1;
  localparam logic [CfgIdxW-1:0]   CfgUnused = 8'hFF;
  localparam logic [CfgIdxW-1:0]   CfgFirstUnused = 8'd2;

  typedef struct packed {
    logic [KeyIdW-1:0] key_id;
    logic              kind;
    logic              last;
  } key_event_t;

  class key_event_scoreboard;
    key_phase_e           key_phase[NumKeys];
    logic [TICK_BITS-1:0] key_ticks[NumKeys];
    logic [CfgDataW-1:0]  press_thr;
    logic [CfgDataW-1:0]  release_thr;
    key_event_t           pending_events[$];
    int unsigned          mismatches;
    int unsigned          rows_seen;
    int unsigned          events_seen;
    int unsigned          reg_writes;

    function new();
      foreach (key_phase[k]) begin
        key_phase[k] = PhIdle;
        key_ticks[k] = '0;
      end
      press_thr   = TicksReset;
      release_thr = TicksReset;
      mismatches  = 0;
      rows_seen   = 0;
      events_seen = 0;
      reg_writes  = 0;
    endfunction

    function void report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void set_threshold(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      reg_writes++;
      if (idx == CfgPressTicks) begin
        press_thr = data;
      end else if (idx == CfgReleaseTicks) begin
        release_thr = data;
      end
    endfunction

    function void note_row(logic [InDataW-1:0] beat);
      logic [RowInW-1:0]    row;
      logic [LevelBits-1:0] levels;
      key_event_t           found[$];
      int unsigned          k;
      logic                 high;
      logic                 fire;
      logic                 kind;
      row    = beat[RowInW-1:0];
      levels = beat[RowInW +: LevelBits];
      rows_seen++;
      if (row >= ROWS) return;
      for (int c = 0; c < ScanCols; c++) begin
        k    = row * COLS + c;
        high = levels[c];
        fire = 1'b0;
        kind = 1'b0;
        case (key_phase[k])
          PhIdle: begin
            if (!high) begin
              key_ticks[k] = '0;
              key_phase[k] = PhPressDb;
            end
          end
          PhPressDb: begin
            if (!high) begin
              if (key_ticks[k] != TickMax) key_ticks[k]++;
              if (key_ticks[k] >= press_thr) begin
                key_ticks[k] = '0;
                key_phase[k] = PhPressed;
                fire = 1'b1;
                kind = 1'b1;
              end
            end
          end
          PhPressed: begin
            if (high) begin
              key_ticks[k] = '0;
              key_phase[k] = PhReleaseDb;
            end
          end
          default: begin
            if (high) begin
              if (key_ticks[k] != TickMax) key_ticks[k]++;
              if (key_ticks[k] >= release_thr) begin
                key_ticks[k] = '0;
                key_phase[k] = PhIdle;
                fire = 1'b1;
              end
            end
          end
        endcase
        if (fire) found.push_back('{key_id: k[KeyIdW-1:0], kind: kind, last: 1'b0});
      end
      foreach (found[i]) begin
        found[i].last = (i == found.size() - 1);
        pending_events.push_back(found[i]);
      end
    endfunction

    function void check_event(logic [KeyIdW-1:0] key_id, logic kind, logic last);
      key_event_t exp_ev;
      events_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat key %0d kind %0d last %0d",
                                  key_id, kind, last));
        return;
      end
      exp_ev = pending_events.pop_front();
      if (key_id !== exp_ev.key_id)
        report_mismatch($sformatf("key_id %0d, want %0d", key_id, exp_ev.key_id));
      if (kind !== exp_ev.kind)
        report_mismatch($sformatf("event_kind %0d, want %0d (key %0d)",
                                  kind, exp_ev.kind, exp_ev.key_id));
      if (last !== exp_ev.last)
        report_mismatch($sformatf("last_event %0d, want %0d (key %0d)",
                                  last, exp_ev.last, exp_ev.key_id));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  key_event_scoreboard sb = new();
  logic                full_rate = 1'b0;
  logic [LevelBits-1:0] held_levels[ROWS];
  int unsigned         idle_cycles = 0;

  matrix_key_debounce_scanner #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TICK_BITS (TICK_BITS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // beat monitor and scoreboard feed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.set_threshold(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_row(s_tdata);
      if (m_tvalid && m_tready) sb.check_event(m_tdata[KeyIdW-1:0], m_tuser, m_tlast);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no beat for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // output back-pressure
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = full_rate ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
      @(negedge clk_i);
    end
  end

  task automatic send_row(logic [RowInW-1:0] row, logic [LevelBits-1:0] levels);
    int unsigned gap;
    gap = full_rate ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'({levels, row});
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    @(negedge clk_i);
  endtask

  // caller lowers cfg_valid after the last write of a group
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending_events.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // mostly held patterns on two focus rows so keys get through debounce
  task automatic send_random_row(logic [RowInW-1:0] focus_a, logic [RowInW-1:0] focus_b);
    logic [RowInW-1:0]    row;
    logic [LevelBits-1:0] levels;
    if ($urandom_range(0, 3) != 0) begin
      row = $urandom_range(0, 1) ? focus_a : focus_b;
      if ($urandom_range(0, 4) == 0) held_levels[row] = LevelBits'($urandom_range(0, 255));
      levels = held_levels[row];
      if ($urandom_range(0, 5) == 0)
        levels[ColIdxW'($urandom_range(0, LevelBits - 1))] ^= 1'b1;
    end else begin
      row    = RowInW'($urandom_range(0, ROWS - 1));
      levels = LevelBits'($urandom_range(0, 255));
    end
    send_row(row, levels);
  endtask

  initial begin
    logic [RowInW-1:0] focus_a;
    logic [RowInW-1:0] focus_b;
    foreach (held_levels[r]) held_levels[r] = '1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset thresholds: full-row press and release, glitches during debounce
    send_row(3'd0, 8'h00);
    send_row(3'd0, 8'hFF);
    send_row(3'd0, 8'h00);
    send_row(3'd0, 8'h00);
    send_row(3'd0, 8'h00);
    send_row(3'd0, 8'hFF);
    send_row(3'd0, 8'h00);
    send_row(3'd0, 8'hFF);
    send_row(3'd0, 8'hFF);
    send_row(3'd7, 8'h55);
    send_row(3'd7, 8'hAA);
    send_row(3'd7, 8'h00);
    send_row(3'd7, 8'h00);
    send_row(3'd3, 8'hFE);
    send_row(3'd3, 8'h7F);
    wait_drained();

    // zero thresholds, plus writes to unused indexes
    write_reg(CfgPressTicks, 16'h0000);
    write_reg(CfgReleaseTicks, 16'h0000);
    write_reg(CfgUnused, 16'hFFFF);
    write_reg(CfgFirstUnused, 16'h0001);
    cfg_valid <= 1'b0;
    send_row(3'd3, 8'h7E);
    send_row(3'd3, 8'hFF);
    send_row(3'd3, 8'hFF);
    send_row(3'd7, 8'hFF);
    send_row(3'd7, 8'hFF);
    wait_drained();

    // max thresholds: keys park in debounce
    write_reg(CfgPressTicks, 16'hFFFF);
    write_reg(CfgReleaseTicks, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_row(3'd5, 8'h00);
    send_row(3'd5, 8'h00);
    send_row(3'd5, 8'hFF);
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CfgPressTicks, CfgDataW'($urandom_range(0, 3)));
      write_reg(CfgReleaseTicks, CfgDataW'($urandom_range(0, 3)));
      cfg_valid <= 1'b0;
      full_rate = (p == 2);
      focus_a   = RowInW'($urandom_range(0, ROWS - 1));
      focus_b   = RowInW'($urandom_range(0, ROWS - 1));
      repeat (RowsPerPhase) send_random_row(focus_a, focus_b);
      wait_drained();
    end

    if (sb.pending_events.size() != 0)
      sb.report_mismatch($sformatf("%0d events never arrived", sb.pending_events.size()));
    $display("Run covered %0d row scans, %0d key event beats, %0d register writes",
             sb.rows_seen, sb.events_seen, sb.reg_writes);
    $display("Thresholds swept from zero to full scale; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
